/* hw/rtl/etint_pkg.sv */
// Shared constants, types and helper functions of the eased translation interpolator.
// No dependencies; every other file of the block uses this package by scoped names.
package etint_pkg;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    localparam int TIME_BITS     = 24;
    localparam int FRAC_BITS     = 16;
    localparam int POS_BITS      = 32;
    localparam int STEP_IN_BITS  = 16;
    localparam int MODE_BITS     = 4;
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 32;

    // weight / progress in Q0.FRAC_BITS, one extra bit so that 1.0 fits
    localparam int W_BITS    = FRAC_BITS + 1;
    // elapsed time plus one step, before wrap or clamp
    localparam int SUM_BITS  = max_int(TIME_BITS, STEP_IN_BITS) + 1;
    // serial shift length: quotient and dividend bit streams
    localparam int SER_BITS  = max_int(SUM_BITS, W_BITS);
    localparam int CNT_BITS  = $clog2(SER_BITS);
    // divisor / remainder width: covers the span and x^2+(1-x)^2
    localparam int DIV_BITS  = max_int(2 * FRAC_BITS + 1, TIME_BITS);
    // signed multiplicand: axis difference or small curve operands
    localparam int MC_BITS   = max_int(POS_BITS + 1, FRAC_BITS + 3);
    localparam int PROD_BITS = MC_BITS + 1 + W_BITS;

    localparam logic [W_BITS-1:0] ONE_W = W_BITS'(1) << FRAC_BITS;
    localparam logic [W_BITS-1:0] HALF_W = W_BITS'(1) << (FRAC_BITS - 1);
    localparam logic [FRAC_BITS+1:0] TWO_ONE = (FRAC_BITS + 2)'(1) << (FRAC_BITS + 1);

    localparam logic [CNT_BITS-1:0] CNT_SER = CNT_BITS'(SER_BITS - 1);
    localparam logic [CNT_BITS-1:0] CNT_W   = CNT_BITS'(W_BITS - 1);

    // curve select codes, mode_bits[1:0]
    localparam logic [1:0] CURVE_LINEAR   = 2'd0;
    localparam logic [1:0] CURVE_EASE     = 2'd1;
    localparam logic [1:0] CURVE_EASE_OUT = 2'd2;

    localparam int MODE_LOOP_BIT   = 2;
    localparam int MODE_MIRROR_BIT = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_START_X = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_Y = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_Z = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_END_X   = 4'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_END_Y   = 4'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_END_Z   = 4'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPAN    = 4'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_MODE    = 4'd7;

    typedef logic signed [POS_BITS-1:0] pos_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TIME,
        ST_MOD,
        ST_MSTORE,
        ST_PLOAD,
        ST_PROG,
        ST_PSEL,
        ST_CMUL,
        ST_CSEL,
        ST_CDIV,
        ST_DSEL,
        ST_MLOAD,
        ST_MIX,
        ST_WRITE
    } state_t;

    // control of a serial unit: load operands, or advance one bit
    typedef struct packed {
        logic load;
        logic step;
    } ser_ctrl_t;

    // triangle fold: 2x up to one half, 2(1-x) above
    function automatic logic [W_BITS-1:0] fold(input logic [W_BITS-1:0] x);
        logic [W_BITS-1:0] res;
        if (x <= (ONE_W >> 1))
            res = x << 1;
        else
            res = (ONE_W - x) << 1;
        return res;
    endfunction

endpackage

/* hw/rtl/etint_if.sv */
// Handshake channel interfaces: input item, result item and configuration write.
// Depends on etint_pkg for field widths.
interface etint_item_if;
    logic                               valid;
    logic                               ready;
    logic [etint_pkg::STEP_IN_BITS-1:0] time_step;
    logic                               restart;

    modport source (output valid, time_step, restart, input ready);
    modport sink   (input valid, time_step, restart, output ready);
endinterface

interface etint_result_if;
    logic                         valid;
    logic                         ready;
    etint_pkg::pos_t              pos_x;
    etint_pkg::pos_t              pos_y;
    etint_pkg::pos_t              pos_z;
    logic [etint_pkg::W_BITS-1:0] weight;

    modport source (output valid, pos_x, pos_y, pos_z, weight, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, weight, output ready);
endinterface

interface etint_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [etint_pkg::CFG_IDX_BITS-1:0]  index;
    logic [etint_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/etint_sdiv.sv */
// Bit-serial restoring divider, one quotient bit per step.
// Depends on etint_pkg (widths, ser_ctrl_t).
module etint_sdiv (
    input  logic                           clk,
    input  etint_pkg::ser_ctrl_t           ctrl,
    input  logic [etint_pkg::DIV_BITS-1:0] init_rem,
    input  logic [etint_pkg::DIV_BITS-1:0] divisor,
    input  logic [etint_pkg::SER_BITS-1:0] dividend,
    output logic [etint_pkg::SER_BITS-1:0] quotient,
    output logic [etint_pkg::DIV_BITS-1:0] remainder
);

    logic [etint_pkg::DIV_BITS-1:0] rem_reg, rem_next;
    logic [etint_pkg::DIV_BITS-1:0] div_reg, div_next;
    logic [etint_pkg::SER_BITS-1:0] din_reg, din_next;
    logic [etint_pkg::SER_BITS-1:0] quo_reg, quo_next;
    logic [etint_pkg::DIV_BITS:0]   shifted;
    logic [etint_pkg::DIV_BITS:0]   dext;
    logic [etint_pkg::DIV_BITS:0]   sub;
    logic                           ge;

    // remainder stays below the divisor, so the shifted value fits one extra bit
    always_comb
    begin
        shifted  = {rem_reg, din_reg[etint_pkg::SER_BITS-1]};
        dext     = {1'b0, div_reg};
        ge       = (shifted >= dext);
        sub      = shifted - dext;
        rem_next = rem_reg;
        div_next = div_reg;
        din_next = din_reg;
        quo_next = quo_reg;
        if (ctrl.load)
        begin
            rem_next = init_rem;
            div_next = divisor;
            din_next = dividend;
            quo_next = '0;
        end
        else if (ctrl.step)
        begin
            rem_next = ge ? sub[etint_pkg::DIV_BITS-1:0] : shifted[etint_pkg::DIV_BITS-1:0];
            din_next = {din_reg[etint_pkg::SER_BITS-2:0], 1'b0};
            quo_next = {quo_reg[etint_pkg::SER_BITS-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        din_reg <= din_next;
        quo_reg <= quo_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* hw/rtl/etint_smul.sv */
// Bit-serial shift-add multiplier: signed multiplicand by unsigned multiplier,
// one multiplier bit per step, LSB first. Depends on etint_pkg.
module etint_smul (
    input  logic                                   clk,
    input  etint_pkg::ser_ctrl_t                   ctrl,
    input  logic signed [etint_pkg::MC_BITS-1:0]   mcand,
    input  logic [etint_pkg::W_BITS-1:0]           mplr,
    output logic signed [etint_pkg::PROD_BITS-1:0] product
);

    logic signed [etint_pkg::MC_BITS-1:0] mc_reg, mc_next;
    logic signed [etint_pkg::MC_BITS:0]   hi_reg, hi_next;
    logic [etint_pkg::W_BITS-1:0]         lo_reg, lo_next;
    logic signed [etint_pkg::MC_BITS:0]   addend;
    logic signed [etint_pkg::MC_BITS:0]   sum;

    // partial sum magnitude stays below twice the multiplicand: no overflow
    always_comb
    begin
        addend  = lo_reg[0] ? (etint_pkg::MC_BITS + 1)'(mc_reg) : '0;
        sum     = hi_reg + addend;
        mc_next = mc_reg;
        hi_next = hi_reg;
        lo_next = lo_reg;
        if (ctrl.load)
        begin
            mc_next = mcand;
            hi_next = '0;
            lo_next = mplr;
        end
        else if (ctrl.step)
        begin
            hi_next = {sum[etint_pkg::MC_BITS], sum[etint_pkg::MC_BITS:1]};
            lo_next = {sum[0], lo_reg[etint_pkg::W_BITS-1:1]};
        end
    end

    always_ff @(posedge clk)
    begin
        mc_reg <= mc_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign product = {hi_reg, lo_reg};

endmodule

/* hw/rtl/eased_translation_interpolator_core.sv */
// Top level of the eased translation interpolator: configuration registers,
// sequencer, one serial divider and three serial multipliers.
// Depends on etint_pkg, etint_if, etint_sdiv, etint_smul.
//
//  channel  dir  transfer when          payload
//  item     in   item.valid&item.ready  time_step[15:0], restart
//  result   out  result.valid&ready     pos_x, pos_y, pos_z (Q16.16), weight[16:0]
//  cfg      in   cfg.valid&cfg.ready    index[3:0], data[31:0]; ready always high
//
// One item at a time. Loop mode adds a 25-bit serial modulo, ease-out a 17-step
// multiply, and ease a multiply and a 17-step divide. The serial divider and
// multipliers retire one bit per cycle.
// The result register frees the input side: the next item is taken while a result
// waits. Reset clears elapsed time, registers (span 1) and the handshake state.
module eased_translation_interpolator_core (
    input  logic           clk,
    input  logic           rst_n,
    etint_item_if.sink     item,
    etint_result_if.source result,
    etint_cfg_if.sink      cfg
);

    localparam int TB = etint_pkg::TIME_BITS;
    localparam int SB = etint_pkg::SUM_BITS;
    localparam int WB = etint_pkg::W_BITS;
    localparam int FB = etint_pkg::FRAC_BITS;
    localparam int DB = etint_pkg::DIV_BITS;
    localparam int PB = etint_pkg::POS_BITS;

    // configuration
    etint_pkg::pos_t                 start_x_reg, start_y_reg, start_z_reg;
    etint_pkg::pos_t                 end_x_reg, end_y_reg, end_z_reg;
    logic [TB-1:0]                   span_reg;
    logic [etint_pkg::MODE_BITS-1:0] mode_reg;

    etint_pkg::state_t               state_reg, state_next;
    logic [etint_pkg::CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [TB-1:0]                   elapsed_reg, elapsed_next;
    logic [SB-1:0]                   t_reg, t_next;
    logic [WB-1:0]                   w_reg, w_next;
    logic                            out_valid_reg, out_valid_next;
    etint_pkg::pos_t                 pos_x_reg, pos_y_reg, pos_z_reg;
    logic [WB-1:0]                   weight_reg;
    logic                            out_load;

    etint_pkg::ser_ctrl_t            div_ctrl, mul_ctrl;
    logic [DB-1:0]                   div_init, div_divisor;
    logic [etint_pkg::SER_BITS-1:0]  div_dividend;
    logic [etint_pkg::SER_BITS-1:0]  div_quo;
    logic [DB-1:0]                   div_rem;

    logic signed [etint_pkg::MC_BITS-1:0]   mc0, mc1, mc2;
    logic [WB-1:0]                          mp0, mp1, mp2;
    logic signed [etint_pkg::PROD_BITS-1:0] prod0, prod1, prod2;

    logic [TB-1:0]          span_eff;
    logic [1:0]             curve;
    logic                   loop_mode, mirror;
    logic [WB-1:0]          x_q;
    logic [WB-1:0]          x_ease;
    logic [2*FB:0]          sq_a, sq_c, sq_sum;
    logic [2*FB+1:0]        eo_sum;
    logic                   round_up;
    logic [WB:0]            q_rnd;
    logic signed [PB:0]     diff_x, diff_y, diff_z;
    logic [etint_pkg::PROD_BITS-1:0] mix_x, mix_y, mix_z;

    assign span_eff  = (span_reg == '0) ? TB'(1) : span_reg;
    assign curve     = mode_reg[1:0];
    assign loop_mode = mode_reg[etint_pkg::MODE_LOOP_BIT];
    assign mirror    = mode_reg[etint_pkg::MODE_MIRROR_BIT];

    assign x_q    = div_quo[WB-1:0];
    assign x_ease = mirror ? etint_pkg::fold(x_q) : x_q;
    assign sq_a   = prod0[2*FB:0];
    assign sq_c   = prod1[2*FB:0];
    // x^2 + (1-x)^2 never exceeds one, so the sum fits
    assign sq_sum = sq_a + sq_c;
    assign eo_sum = prod0[2*FB+1:0] + (2*FB + 2)'(etint_pkg::HALF_W);
    assign round_up = ({div_rem, 1'b0} >= {1'b0, DB'(sq_sum)});
    assign q_rnd    = {1'b0, x_q} + (WB + 1)'(round_up);

    assign diff_x = $signed({end_x_reg[PB-1], end_x_reg}) - $signed({start_x_reg[PB-1], start_x_reg});
    assign diff_y = $signed({end_y_reg[PB-1], end_y_reg}) - $signed({start_y_reg[PB-1], start_y_reg});
    assign diff_z = $signed({end_z_reg[PB-1], end_z_reg}) - $signed({start_z_reg[PB-1], start_z_reg});

    // rounding half up then floor shift equals a plain bit slice of the sum
    assign mix_x = prod0 + etint_pkg::PROD_BITS'(etint_pkg::HALF_W);
    assign mix_y = prod1 + etint_pkg::PROD_BITS'(etint_pkg::HALF_W);
    assign mix_z = prod2 + etint_pkg::PROD_BITS'(etint_pkg::HALF_W);

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            start_z_reg <= '0;
            end_x_reg   <= '0;
            end_y_reg   <= '0;
            end_z_reg   <= '0;
            span_reg    <= TB'(1);
            mode_reg    <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                etint_pkg::REG_START_X: start_x_reg <= cfg.data;
                etint_pkg::REG_START_Y: start_y_reg <= cfg.data;
                etint_pkg::REG_START_Z: start_z_reg <= cfg.data;
                etint_pkg::REG_END_X:   end_x_reg   <= cfg.data;
                etint_pkg::REG_END_Y:   end_y_reg   <= cfg.data;
                etint_pkg::REG_END_Z:   end_z_reg   <= cfg.data;
                etint_pkg::REG_SPAN:    span_reg    <= cfg.data[TB-1:0];
                etint_pkg::REG_MODE:    mode_reg    <= cfg.data[etint_pkg::MODE_BITS-1:0];
                default:                ;
            endcase
        end
    end

    // operand selection for the serial units
    always_comb
    begin
        div_init     = '0;
        div_divisor  = DB'(span_eff);
        div_dividend = etint_pkg::SER_BITS'(t_reg);
        unique case (state_reg)
            etint_pkg::ST_PLOAD:
            begin
                div_init     = DB'(elapsed_reg[TB-1:1]);
                div_dividend = {elapsed_reg[0], (etint_pkg::SER_BITS - 1)'(0)};
            end
            etint_pkg::ST_CSEL:
            begin
                div_init     = DB'(sq_a[2*FB:1]);
                div_divisor  = DB'(sq_sum);
                div_dividend = {sq_a[0], (etint_pkg::SER_BITS - 1)'(0)};
            end
            default: ;
        endcase
    end

    always_comb
    begin
        mc0 = etint_pkg::MC_BITS'(diff_x);
        mc1 = etint_pkg::MC_BITS'(diff_y);
        mc2 = etint_pkg::MC_BITS'(diff_z);
        mp0 = w_reg;
        mp1 = w_reg;
        mp2 = w_reg;
        if (state_reg == etint_pkg::ST_PSEL)
        begin
            if (curve == etint_pkg::CURVE_EASE)
            begin
                mc0 = $signed(etint_pkg::MC_BITS'(x_ease));
                mp0 = x_ease;
                mc1 = $signed(etint_pkg::MC_BITS'(etint_pkg::ONE_W - x_ease));
                mp1 = etint_pkg::ONE_W - x_ease;
            end
            else
            begin
                mc0 = $signed(etint_pkg::MC_BITS'(etint_pkg::TWO_ONE - (FB + 2)'(x_q)));
                mp0 = x_q;
            end
        end
    end

    etint_sdiv u_div (
        .clk       (clk),
        .ctrl      (div_ctrl),
        .init_rem  (div_init),
        .divisor   (div_divisor),
        .dividend  (div_dividend),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    etint_smul u_mul0 (.clk(clk), .ctrl(mul_ctrl), .mcand(mc0), .mplr(mp0), .product(prod0));
    etint_smul u_mul1 (.clk(clk), .ctrl(mul_ctrl), .mcand(mc1), .mplr(mp1), .product(prod1));
    etint_smul u_mul2 (.clk(clk), .ctrl(mul_ctrl), .mcand(mc2), .mplr(mp2), .product(prod2));

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        elapsed_next   = elapsed_reg;
        t_next         = t_reg;
        w_next         = w_reg;
        div_ctrl       = '0;
        mul_ctrl       = '0;
        out_load       = 1'b0;
        item.ready     = 1'b0;
        unique case (state_reg)
            etint_pkg::ST_IDLE:
            begin
                item.ready = 1'b1;
                if (item.valid)
                begin
                    t_next = (item.restart ? '0 : SB'(elapsed_reg)) + SB'(item.time_step);
                    state_next = etint_pkg::ST_TIME;
                end
            end
            etint_pkg::ST_TIME:
            begin
                if (loop_mode)
                begin
                    div_ctrl.load = 1'b1;
                    cnt_next      = etint_pkg::CNT_SER;
                    state_next    = etint_pkg::ST_MOD;
                end
                else
                begin
                    elapsed_next = (t_reg > SB'(span_eff)) ? span_eff : t_reg[TB-1:0];
                    state_next   = etint_pkg::ST_PLOAD;
                end
            end
            etint_pkg::ST_MOD:
            begin
                div_ctrl.step = 1'b1;
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = etint_pkg::ST_MSTORE;
            end
            etint_pkg::ST_MSTORE:
            begin
                elapsed_next = div_rem[TB-1:0];
                state_next   = etint_pkg::ST_PLOAD;
            end
            etint_pkg::ST_PLOAD:
            begin
                div_ctrl.load = 1'b1;
                cnt_next      = etint_pkg::CNT_W;
                state_next    = etint_pkg::ST_PROG;
            end
            etint_pkg::ST_PROG:
            begin
                div_ctrl.step = 1'b1;
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = etint_pkg::ST_PSEL;
            end
            etint_pkg::ST_PSEL:
            begin
                case (curve) inside
                    etint_pkg::CURVE_EASE, etint_pkg::CURVE_EASE_OUT:
                    begin
                        mul_ctrl.load = 1'b1;
                        cnt_next      = etint_pkg::CNT_W;
                        state_next    = etint_pkg::ST_CMUL;
                    end
                    default:
                    begin
                        w_next     = mirror ? etint_pkg::fold(x_q) : x_q;
                        state_next = etint_pkg::ST_MLOAD;
                    end
                endcase
            end
            etint_pkg::ST_CMUL:
            begin
                mul_ctrl.step = 1'b1;
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = etint_pkg::ST_CSEL;
            end
            etint_pkg::ST_CSEL:
            begin
                if (curve == etint_pkg::CURVE_EASE)
                begin
                    div_ctrl.load = 1'b1;
                    cnt_next      = etint_pkg::CNT_W;
                    state_next    = etint_pkg::ST_CDIV;
                end
                else
                begin
                    w_next     = eo_sum[2*FB:FB];
                    state_next = etint_pkg::ST_MLOAD;
                end
            end
            etint_pkg::ST_CDIV:
            begin
                div_ctrl.step = 1'b1;
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = etint_pkg::ST_DSEL;
            end
            etint_pkg::ST_DSEL:
            begin
                w_next     = (q_rnd > (WB + 1)'(etint_pkg::ONE_W)) ? etint_pkg::ONE_W
                                                                    : q_rnd[WB-1:0];
                state_next = etint_pkg::ST_MLOAD;
            end
            etint_pkg::ST_MLOAD:
            begin
                mul_ctrl.load = 1'b1;
                cnt_next      = etint_pkg::CNT_W;
                state_next    = etint_pkg::ST_MIX;
            end
            etint_pkg::ST_MIX:
            begin
                mul_ctrl.step = 1'b1;
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = etint_pkg::ST_WRITE;
            end
            etint_pkg::ST_WRITE:
            begin
                // wait here only while the previous result is still unclaimed
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = etint_pkg::ST_IDLE;
                end
            end
            default:
                state_next = etint_pkg::ST_IDLE;
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= etint_pkg::ST_IDLE;
            cnt_reg       <= '0;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            elapsed_reg   <= elapsed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
        w_reg <= w_next;
        if (out_load)
        begin
            pos_x_reg  <= start_x_reg + $signed(mix_x[FB+PB-1:FB]);
            pos_y_reg  <= start_y_reg + $signed(mix_y[FB+PB-1:FB]);
            pos_z_reg  <= start_z_reg + $signed(mix_z[FB+PB-1:FB]);
            weight_reg <= w_reg;
        end
    end

    assign result.valid  = out_valid_reg;
    assign result.pos_x  = pos_x_reg;
    assign result.pos_y  = pos_y_reg;
    assign result.pos_z  = pos_z_reg;
    assign result.weight = weight_reg;

endmodule

/* hw/rtl/etint_check.sv */
// Port-level checker for the eased translation interpolator, bound to the top level.
// Depends on etint_pkg and on eased_translation_interpolator_core.
module etint_check (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         item_valid,
    input logic                         item_ready,
    input logic                         result_valid,
    input logic                         result_ready,
    input etint_pkg::pos_t              pos_x,
    input etint_pkg::pos_t              pos_y,
    input etint_pkg::pos_t              pos_z,
    input logic [etint_pkg::W_BITS-1:0] weight
);

    // items taken minus results delivered
    logic [1:0] pend_reg, pend_next;

    always_comb
    begin
        pend_next = pend_reg + 2'((item_valid && item_ready) ? 1 : 0)
                             - 2'((result_valid && result_ready) ? 1 : 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("input taken while an item is still in work");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(pos_x) && $stable(pos_y)
            && $stable(pos_z) && $stable(weight))
        else $error("stalled result changed");

    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> weight <= etint_pkg::ONE_W)
        else $error("weight above one");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pend_reg != 2'd0)
        else $error("result without a pending item");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two items outstanding");

endmodule

bind eased_translation_interpolator_core etint_check u_etint_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .pos_x        (result.pos_x),
    .pos_y        (result.pos_y),
    .pos_z        (result.pos_z),
    .weight       (result.weight)
);

/* sim/tb_eased_translation_interpolator_core.sv */
// Self-checking testbench of the eased translation interpolator core.
// Needs etint_pkg, the etint_*_if interfaces and the core. A built-in predictor, or hand
// values on typed rows, checks every result of a directed table and of random ticks under many settings.
`timescale 1ns / 100ps

module tb_eased_translation_interpolator_core;

    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          BLOCKS       = 28;
    localparam int          BLOCK_TICKS  = 50;
    localparam int          HOLD_CYCLES  = 800;
    localparam int          DRAIN_CYCLES = 120;
    localparam logic [63:0] UNIT_Q       = 64'd1 << etint_pkg::FRAC_BITS;
    localparam logic [63:0] TIME_MASK_Q  = (64'd1 << etint_pkg::TIME_BITS) - 64'd1;
    localparam logic [1:0]  CURVE_SPARE  = 2'd3;
    localparam logic [etint_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 4'd12;

    typedef struct packed {
        etint_pkg::pos_t              px;
        etint_pkg::pos_t              py;
        etint_pkg::pos_t              pz;
        logic [etint_pkg::W_BITS-1:0] wt;
    } pose_t;

    typedef enum logic {ROW_CFG, ROW_TICK} row_kind_t;

    typedef struct {
        row_kind_t                           kind;
        logic [etint_pkg::CFG_IDX_BITS-1:0]  idx;
        logic [etint_pkg::CFG_DATA_BITS-1:0] data;
        logic [etint_pkg::STEP_IN_BITS-1:0]  step;
        logic                                rs;
        bit                                  typed;
        pose_t                               want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n;

    etint_item_if   tick_ch ();
    etint_result_if pose_ch ();
    etint_cfg_if    cfg_ch ();

    eased_translation_interpolator_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (tick_ch),
        .result (pose_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor copy of registers and elapsed time
    logic [31:0]                     start_r [3];
    logic [31:0]                     end_r [3];
    logic [23:0]                     span_r;
    logic [etint_pkg::MODE_BITS-1:0] mode_r;
    logic [etint_pkg::TIME_BITS-1:0] elapsed_r;

    pose_t pending_poses [$];
    pose_t oldest_pose;
    row_t  rows [$];
    int    fail_count = 0;
    int    cycle_count = 0;
    int    send_idle_pct = 12;
    int    recv_idle_pct = 65;
    bit    stall_request = 1'b0;

    task automatic flag_error(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        fail_count++;
    endtask

    function automatic void apply_reg(input logic [etint_pkg::CFG_IDX_BITS-1:0] idx,
                                      input logic [etint_pkg::CFG_DATA_BITS-1:0] d);
        unique case (idx)
            etint_pkg::REG_START_X: start_r[0] = d;
            etint_pkg::REG_START_Y: start_r[1] = d;
            etint_pkg::REG_START_Z: start_r[2] = d;
            etint_pkg::REG_END_X:   end_r[0] = d;
            etint_pkg::REG_END_Y:   end_r[1] = d;
            etint_pkg::REG_END_Z:   end_r[2] = d;
            etint_pkg::REG_SPAN:    span_r = d[23:0];
            etint_pkg::REG_MODE:    mode_r = d[etint_pkg::MODE_BITS-1:0];
            default:                ;
        endcase
    endfunction

    function automatic logic [31:0] mode_word(input logic [1:0] curve, input bit lp,
                                              input bit mir);
        logic [31:0] m;
        m = '0;
        m[1:0] = curve;
        m[etint_pkg::MODE_LOOP_BIT] = lp;
        m[etint_pkg::MODE_MIRROR_BIT] = mir;
        return m;
    endfunction

    // x^2 / (x^2 + (1-x)^2), rounded to nearest
    function automatic logic [63:0] ease_weight(input logic [63:0] x, input bit mir);
        logic [63:0] a, c, s, q, r;
        if (mir)
        begin
            x = x << 1;
            if (x > UNIT_Q)
                x = (UNIT_Q << 1) - x;
        end
        a = x * x;
        c = (UNIT_Q - x) * (UNIT_Q - x);
        s = a + c;
        q = (a << etint_pkg::FRAC_BITS) / s;
        r = (a << etint_pkg::FRAC_BITS) % s;
        if ((r << 1) >= s)
            q = q + 64'd1;
        return (q > UNIT_Q) ? UNIT_Q : q;
    endfunction

    function automatic etint_pkg::pos_t blend_axis(input logic [31:0] a,
                                                   input logic [31:0] b,
                                                   input logic [63:0] w);
        logic signed [63:0] f, d, wv, hv, n, sum;
        f   = {{32{a[31]}}, a};
        d   = {{32{b[31]}}, b} - f;
        wv  = w;
        hv  = UNIT_Q >> 1;
        n   = d * wv + hv;
        sum = f + (n >>> etint_pkg::FRAC_BITS);
        return sum[31:0];
    endfunction

    function automatic pose_t advance_pose(input logic [etint_pkg::STEP_IN_BITS-1:0] step,
                                           input logic rs);
        logic [63:0] spn, t, x, w;
        pose_t       p;
        spn = (span_r == 24'd0) ? 64'd1 : 64'(span_r);
        t   = rs ? 64'd0 : 64'(elapsed_r);
        t   = t + 64'(step);
        if (mode_r[etint_pkg::MODE_LOOP_BIT])
            t = t % spn;
        else if (t > spn)
            t = spn;
        t = t & TIME_MASK_Q;
        elapsed_r = t[etint_pkg::TIME_BITS-1:0];
        x = (t << etint_pkg::FRAC_BITS) / spn;
        if (x > UNIT_Q)
            x = UNIT_Q;
        case (mode_r[1:0])
            etint_pkg::CURVE_EASE:
                w = ease_weight(x, mode_r[etint_pkg::MODE_MIRROR_BIT]);
            etint_pkg::CURVE_EASE_OUT:
                w = (x * ((UNIT_Q << 1) - x) + (UNIT_Q >> 1)) >> etint_pkg::FRAC_BITS;
            default:
            begin
                // linear, also for the spare curve code
                if (!mode_r[etint_pkg::MODE_MIRROR_BIT])
                    w = x;
                else if (x <= (UNIT_Q >> 1))
                    w = x << 1;
                else
                    w = (UNIT_Q - x) << 1;
            end
        endcase
        p.px = blend_axis(start_r[0], end_r[0], w);
        p.py = blend_axis(start_r[1], end_r[1], w);
        p.pz = blend_axis(start_r[2], end_r[2], w);
        p.wt = w[etint_pkg::W_BITS-1:0];
        return p;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic push_tick(input logic [etint_pkg::STEP_IN_BITS-1:0] step, input logic rs,
                             input bit typed, input pose_t want);
        pose_t p;
        while ($urandom_range(99) < send_idle_pct)
        begin
            tick_ch.valid <= 1'b0;
            @(negedge clk);
        end
        tick_ch.valid     <= 1'b1;
        tick_ch.time_step <= step;
        tick_ch.restart   <= rs;
        do
        begin
            @(posedge clk);
        end
        while (!tick_ch.ready);
        p = advance_pose(step, rs);
        pending_poses.push_back(typed ? want : p);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [etint_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [etint_pkg::CFG_DATA_BITS-1:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        apply_reg(idx, d);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // block idle: no tick offered and every result delivered
    task automatic settle();
        tick_ch.valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending_poses.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic add_cfg(input logic [etint_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [etint_pkg::CFG_DATA_BITS-1:0] d);
        row_t r;
        r = '{kind: ROW_CFG, idx: idx, data: d, step: '0, rs: 1'b0, typed: 1'b0, want: '0};
        rows.push_back(r);
    endtask

    task automatic add_tick(input logic [etint_pkg::STEP_IN_BITS-1:0] step, input logic rs,
                            input bit typed, input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] pz,
                            input logic [etint_pkg::W_BITS-1:0] wt);
        row_t r;
        r = '{kind: ROW_TICK, idx: '0, data: '0, step: step, rs: rs, typed: typed,
              want: '{px: px, py: py, pz: pz, wt: wt}};
        rows.push_back(r);
    endtask

    // receiver: random ready, or a long hold-off on request
    initial
    begin
        pose_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                stall_request = 1'b0;
                pose_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                pose_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pose_ch.valid && pose_ch.ready)
        begin
            if (pending_poses.size() == 0)
            begin
                flag_error("result transfer with nothing pending");
            end
            else
            begin
                oldest_pose = pending_poses.pop_front();
                if (pose_ch.pos_x !== oldest_pose.px)
                    flag_error($sformatf("pos_x %h, want %h", pose_ch.pos_x, oldest_pose.px));
                if (pose_ch.pos_y !== oldest_pose.py)
                    flag_error($sformatf("pos_y %h, want %h", pose_ch.pos_y, oldest_pose.py));
                if (pose_ch.pos_z !== oldest_pose.pz)
                    flag_error($sformatf("pos_z %h, want %h", pose_ch.pos_z, oldest_pose.pz));
                if (pose_ch.weight !== oldest_pose.wt)
                    flag_error($sformatf("weight %h, want %h", pose_ch.weight, oldest_pose.wt));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] v;
        logic [23:0] lim;
        int          pick;

        rst_n             = 1'b0;
        tick_ch.valid     = 1'b0;
        tick_ch.time_step = '0;
        tick_ch.restart   = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        for (int k = 0; k < 3; k++)
        begin
            start_r[k] = '0;
            end_r[k]   = '0;
        end
        span_r    = 24'd1;
        mode_r    = '0;
        elapsed_r = '0;

        // directed table; typed rows carry a result read off by hand
        add_tick(16'd0, 1'b0, 1'b1, 32'h0, 32'h0, 32'h0, 17'h0);
        add_tick(16'hFFFF, 1'b0, 1'b1, 32'h0, 32'h0, 32'h0, 17'h10000);
        add_tick(16'd0, 1'b1, 1'b1, 32'h0, 32'h0, 32'h0, 17'h0);
        add_cfg(etint_pkg::REG_START_X, 32'h8000_0000);
        add_cfg(etint_pkg::REG_START_Y, 32'h7FFF_FFFF);
        add_cfg(etint_pkg::REG_START_Z, 32'h0000_0000);
        add_cfg(etint_pkg::REG_END_X, 32'h7FFF_FFFF);
        add_cfg(etint_pkg::REG_END_Y, 32'h8000_0000);
        add_cfg(etint_pkg::REG_END_Z, 32'hFFFF_FFFF);
        add_cfg(etint_pkg::REG_SPAN, 32'h0);  // zero span acts as one
        add_tick(16'd1, 1'b1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 17'h10000);
        add_tick(16'd0, 1'b1, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 17'h0);
        add_tick(16'hFFFF, 1'b0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 17'h10000);
        add_cfg(etint_pkg::REG_SPAN, 32'h00FF_FFFF);
        add_cfg(etint_pkg::REG_MODE, mode_word(etint_pkg::CURVE_LINEAR, 1'b1, 1'b0));
        add_tick(16'hFFFF, 1'b1, 1'b0, '0, '0, '0, '0);
        add_tick(16'hFFFF, 1'b0, 1'b0, '0, '0, '0, '0);
        add_tick(16'h8000, 1'b0, 1'b0, '0, '0, '0, '0);
        add_cfg(etint_pkg::REG_SPAN, 32'd100);
        add_cfg(etint_pkg::REG_MODE, mode_word(etint_pkg::CURVE_LINEAR, 1'b0, 1'b1));
        add_tick(16'd50, 1'b1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 17'h10000);
        add_tick(16'd50, 1'b0, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 17'h0);
        add_cfg(etint_pkg::REG_MODE, mode_word(etint_pkg::CURVE_EASE, 1'b0, 1'b0));
        add_tick(16'd0, 1'b1, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 17'h0);
        add_tick(16'd25, 1'b0, 1'b0, '0, '0, '0, '0);
        add_tick(16'd25, 1'b0, 1'b0, '0, '0, '0, '0);
        // past the end: clamped, progress saturates at one
        add_tick(16'd100, 1'b0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 17'h10000);
        add_cfg(etint_pkg::REG_MODE, mode_word(etint_pkg::CURVE_EASE, 1'b0, 1'b1));
        add_tick(16'd30, 1'b1, 1'b0, '0, '0, '0, '0);
        add_tick(16'd40, 1'b0, 1'b0, '0, '0, '0, '0);
        add_cfg(etint_pkg::REG_MODE, mode_word(etint_pkg::CURVE_EASE_OUT, 1'b0, 1'b0));
        add_tick(16'd33, 1'b1, 1'b0, '0, '0, '0, '0);
        add_tick(16'd67, 1'b0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 17'h10000);
        add_cfg(etint_pkg::REG_MODE, mode_word(etint_pkg::CURVE_EASE_OUT, 1'b0, 1'b1));
        add_tick(16'd50, 1'b1, 1'b0, '0, '0, '0, '0);
        add_cfg(etint_pkg::REG_MODE, mode_word(CURVE_SPARE, 1'b0, 1'b0));
        add_tick(16'd10, 1'b1, 1'b0, '0, '0, '0, '0);
        add_cfg(etint_pkg::REG_MODE, mode_word(CURVE_SPARE, 1'b1, 1'b1));
        add_tick(16'd75, 1'b1, 1'b0, '0, '0, '0, '0);
        add_tick(16'd75, 1'b0, 1'b0, '0, '0, '0, '0);
        add_tick(16'hFFFF, 1'b0, 1'b0, '0, '0, '0, '0);
        add_cfg(REG_UNUSED, 32'hDEAD_BEEF);  // must be dropped
        add_tick(16'd1, 1'b0, 1'b0, '0, '0, '0, '0);
        add_cfg(etint_pkg::REG_SPAN, 32'd7);
        add_cfg(etint_pkg::REG_MODE, mode_word(etint_pkg::CURVE_EASE, 1'b1, 1'b0));
        add_tick(16'd7, 1'b1, 1'b0, '0, '0, '0, '0);
        add_tick(16'd13, 1'b0, 1'b0, '0, '0, '0, '0);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(rows[i].idx, rows[i].data);
            end
            else
            begin
                push_tick(rows[i].step, rows[i].rs, rows[i].typed, rows[i].want);
            end
        end

        for (int blk = 0; blk < BLOCKS; blk++)
        begin
            if (blk < 10)
            begin
                send_idle_pct = 12;
                recv_idle_pct = 65;
            end
            else if (blk < 20)
            begin
                send_idle_pct = 65;
                recv_idle_pct = 12;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            settle();
            for (int k = 0; k < 6; k++)
            begin
                pick = $urandom_range(7);
                case (pick)
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'h0;
                    default: v = $urandom;
                endcase
                write_reg(etint_pkg::REG_START_X + etint_pkg::CFG_IDX_BITS'(k), v);
            end
            pick = $urandom_range(19);
            case (pick) inside
                0:       v = 32'h0;
                1:       v = 32'h00FF_FFFF;
                2:       v = $urandom_range(24'hFF_FFFF);
                [3:5]:   v = $urandom_range(60000, 1000);
                default: v = $urandom_range(300, 1);
            endcase
            // upper bits of the data word are don't-care for the span
            v[31:24] = 8'($urandom);
            write_reg(etint_pkg::REG_SPAN, v);
            v = $urandom;
            write_reg(etint_pkg::REG_MODE, v);
            if ($urandom_range(3) == 0)
                write_reg(REG_UNUSED, $urandom);
            if (blk == 20)
                stall_request = 1'b1;  // receiver holds off, block fills and stalls ticks

            lim = (span_r == 24'd0) ? 24'd1 : span_r;
            if (lim > 24'd65535)
                lim = 24'd65535;
            for (int n = 0; n < BLOCK_TICKS; n++)
            begin
                pick = $urandom_range(19);
                case (pick)
                    0:       v = 32'h0;
                    1:       v = 32'hFFFF;
                    2:       v = $urandom;
                    default: v = $urandom_range(lim / 3 + 1);
                endcase
                push_tick(v[etint_pkg::STEP_IN_BITS-1:0], ($urandom_range(11) == 0), 1'b0, '0);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pending_poses.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_poses.size()));
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* eased_translation_interpolator_core.f */
hw/rtl/etint_pkg.sv
hw/rtl/etint_if.sv
hw/rtl/etint_sdiv.sv
hw/rtl/etint_smul.sv
hw/rtl/eased_translation_interpolator_core.sv
hw/rtl/etint_check.sv
sim/tb_eased_translation_interpolator_core.sv
